// ===== sv/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// dls_pkg
// Types, constants and fixed-point helpers for the damped least-squares solve.
// ----------------------------------------------------------------------------
package dls_pkg;

   localparam int DAMP_W    = 31;
   localparam int NTERM     = 9;
   localparam int DIV_STEPS = 63;

   localparam int FORM_LAT = 4;
   localparam int MUL_LAT  = 4;
   localparam int DIV_LAT  = DIV_STEPS + 2;

   // pipeline timing, in cycles after a beat enters
   localparam int T0  = FORM_LAT;
   localparam int T1  = T0 + DIV_LAT;
   localparam int T2  = T1 + MUL_LAT;
   localparam int T3  = T2 + 1;
   localparam int T4  = T3 + DIV_LAT;
   localparam int T5  = T4 + MUL_LAT;
   localparam int T6  = T5 + 1;
   localparam int T7  = T6 + DIV_LAT;
   localparam int T8  = T7 + MUL_LAT;
   localparam int T9  = T8 + 1;
   localparam int T10 = T9 + MUL_LAT;
   localparam int T11 = T10 + 1;
   localparam int T12 = T11 + 1;
   localparam int PIPE_LAT = T12 + 1;

   localparam logic [DAMP_W-1:0] DAMPING_RESET = 31'd66;

   typedef logic signed [63:0] qval_type;

   localparam qval_type QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] QMAX_X = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] j00;
      logic signed [31:0] j01;
      logic signed [31:0] j02;
      logic signed [31:0] j10;
      logic signed [31:0] j11;
      logic signed [31:0] j12;
      logic signed [31:0] j20;
      logic signed [31:0] j21;
      logic signed [31:0] j22;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } dls_req_type;

   typedef struct packed {
      logic signed [31:0] qd0;
      logic signed [31:0] qd1;
      logic signed [31:0] qd2;
      logic               singular;
   } dls_rsp_type;

   function automatic qval_type sat_add(qval_type a, qval_type b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > QMAX_X) return QMAX;
      else if (s < -QMAX_X) return -QMAX;
      else return s[63:0];
   endfunction

   function automatic qval_type sat_sub(qval_type a, qval_type b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) - $signed({b[63], b});
      if (s > QMAX_X) return QMAX;
      else if (s < -QMAX_X) return -QMAX;
      else return s[63:0];
   endfunction

   function automatic logic [63:0] mag(qval_type a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic logic not_pos(qval_type a);
      return a[63] | (a == 64'sd0);
   endfunction

   function automatic logic signed [31:0] to_q16(qval_type x);
      logic [63:0] m;
      logic [31:0] s;
      m = mag(x) >> 16;
      s = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      return x[63] ? -s : s;
   endfunction

endpackage

// ===== sv/dls_dly.sv =====
// ----------------------------------------------------------------------------
// dls_dly
// Enabled shift line that keeps side values aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module dls_dly #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ===== sv/dls_mulq.sv =====
// ----------------------------------------------------------------------------
// dls_mulq
// Four-stage Q32.32 multiply: sign/magnitude, 32x32 partials, sum with
// saturation, sign restore.
// ----------------------------------------------------------------------------
module dls_mulq import dls_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  qval_type a,
   input  qval_type b,
   output qval_type prod
);

   logic [63:0] ua_ff, ub_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [63:0] pp_ff [4];
   logic [62:0] mag_ff;
   qval_type    prod_ff;
   logic [95:0] sum_in;

   always_comb begin
      sum_in = {pp_ff[3], 32'b0} + {32'b0, pp_ff[1]} + {32'b0, pp_ff[2]}
             + {64'b0, pp_ff[0][63:32]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff    <= mag(a);
         ub_ff    <= mag(b);
         neg1_ff  <= a[63] ^ b[63];
         pp_ff[0] <= 64'(ua_ff[31:0] * ub_ff[31:0]);
         pp_ff[1] <= 64'(ua_ff[31:0] * ub_ff[63:32]);
         pp_ff[2] <= 64'(ua_ff[63:32] * ub_ff[31:0]);
         pp_ff[3] <= 64'(ua_ff[63:32] * ub_ff[63:32]);
         neg2_ff  <= neg1_ff;
         mag_ff   <= (|sum_in[95:63]) ? QMAX[62:0] : sum_in[62:0];
         neg3_ff  <= neg2_ff;
         prod_ff  <= neg3_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      end
   end

   assign prod = prod_ff;

endmodule

// ===== sv/dls_divq.sv =====
// ----------------------------------------------------------------------------
// dls_divq
// Pipelined restoring Q32.32 divide, one quotient bit per stage, with
// saturation when the integer part overflows. Divisor taken as positive.
// ----------------------------------------------------------------------------
module dls_divq import dls_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  qval_type num,
   input  qval_type den,
   output qval_type quo
);

   logic [63:0]          rem_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] nb_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   logic [63:0]          den_ff [DIV_STEPS+1];
   logic                 neg_ff [DIV_STEPS+1];
   logic                 sat_ff [DIV_STEPS+1];
   qval_type             quo_ff;
   logic [63:0]          un_in, r0_in, res_in;

   always_comb begin
      un_in  = mag(num);
      r0_in  = un_in >> 31;
      res_in = sat_ff[DIV_STEPS] ? 64'(QMAX) : {1'b0, q_ff[DIV_STEPS]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0_in;
         nb_ff[0]  <= {un_in[30:0], 32'b0};
         q_ff[0]   <= '0;
         den_ff[0] <= $unsigned(den);
         neg_ff[0] <= num[63];
         sat_ff[0] <= r0_in >= $unsigned(den);
         quo_ff    <= neg_ff[DIV_STEPS] ? -$signed(res_in) : $signed(res_in);
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      logic [63:0] rs;
      logic        ge;
      assign rs = {rem_ff[s-1][62:0], nb_ff[s-1][DIV_STEPS-1]};
      assign ge = rs >= den_ff[s-1];
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? rs - den_ff[s-1] : rs;
            nb_ff[s]  <= {nb_ff[s-1][DIV_STEPS-2:0], 1'b0};
            q_ff[s]   <= {q_ff[s-1][DIV_STEPS-2:0], ge};
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   assign quo = quo_ff;

endmodule

// ===== sv/dls_form.sv =====
// ----------------------------------------------------------------------------
// dls_form
// Forms A = J^T J + damping*I and b = J^T v over four stages with
// saturating accumulation.
// ----------------------------------------------------------------------------
module dls_form import dls_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  dls_req_type       req_data,
   input  logic [DAMP_W-1:0] damping,
   output qval_type          sum_o [NTERM]
);

   // A entries in order a00 a10 a11 a20 a21 a22, then b0 b1 b2
   localparam int ROW [6] = '{0, 1, 1, 2, 2, 2};
   localparam int COL [6] = '{0, 0, 1, 0, 1, 2};

   logic signed [31:0] jm [3][3];
   logic signed [31:0] vv [3];
   qval_type prod_in [NTERM][3];
   qval_type p_ff  [NTERM][3];
   qval_type s1_ff [NTERM];
   qval_type p2_ff [NTERM];
   qval_type s2_ff [NTERM];
   qval_type sum_ff [NTERM];
   qval_type damp_in;

   always_comb begin
      jm[0][0] = req_data.j00; jm[0][1] = req_data.j01; jm[0][2] = req_data.j02;
      jm[1][0] = req_data.j10; jm[1][1] = req_data.j11; jm[1][2] = req_data.j12;
      jm[2][0] = req_data.j20; jm[2][1] = req_data.j21; jm[2][2] = req_data.j22;
      vv[0] = req_data.vel_x;
      vv[1] = req_data.vel_y;
      vv[2] = req_data.vel_z;
      for (int e = 0; e < 6; e++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[e][k] = jm[k][ROW[e]] * jm[k][COL[e]];
         end
      end
      for (int e = 0; e < 3; e++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[e+6][k] = jm[k][e] * vv[k];
         end
      end
      damp_in = $signed({17'b0, damping, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int e = 0; e < NTERM; e++) begin
            for (int k = 0; k < 3; k++) p_ff[e][k] <= prod_in[e][k];
            s1_ff[e] <= sat_add(p_ff[e][0], p_ff[e][1]);
            p2_ff[e] <= p_ff[e][2];
            s2_ff[e] <= sat_add(s1_ff[e], p2_ff[e]);
            sum_ff[e] <= (e == 0 || e == 2 || e == 5) ? sat_add(s2_ff[e], damp_in)
                                                      : s2_ff[e];
         end
      end
   end

   assign sum_o = sum_ff;

endmodule

// ===== sv/damped_least_squares_3x3_solve.sv =====
// ----------------------------------------------------------------------------
// damped_least_squares_3x3_solve
// Damped least-squares joint velocity solve for a 3x3 leg Jacobian: forms
// J^T J + damping*I and J^T v, LDL^T factorization, Q16.16 saturated result.
//
//   channel   ports        dir   beat
//   request   req_*        in    Jacobian and foot velocity, valid/ready
//   response  rsp_*        out   joint velocities and singular flag
//   csr       csr_wr_*     in    damping, written when csr_wr_en is high
//
// One beat per cycle unless a result is held; pipeline depth is set by three
// dependent 65-stage dividers and the multiplies between them.
// When a result is held at the output, the whole pipeline stalls together.
// Reset clears the valid chain and sets damping to 66.
// ----------------------------------------------------------------------------
module damped_least_squares_3x3_solve import dls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dls_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dls_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [DAMP_W-1:0] csr_wr_data
);

   logic              en;
   logic [DAMP_W-1:0] damping_ff;
   logic [PIPE_LAT-1:0] vld_ff;
   dls_rsp_type       rsp_ff;

   qval_type a_w [NTERM];
   qval_type l10, l20, z0, l21, z1, z2;
   qval_type a10_d, a20_d, b0_d, a11_d, a21_d, a22_d, b1_d, b2_d;
   qval_type m_a, m_b, m_c, m_d, m_e, m_f, m_g, m_h, m_i, m_j;
   qval_type d1_ff, t_ff, e_ff, y1_ff, w_ff, d2_ff, y2_ff, q1_ff, u_ff, q0_ff;
   qval_type d1_in, d2_in;
   qval_type t_d, y1_d, e_d, w_d, l21_d, l20_d, l10_d, z1_d, z0_d, m_i_d, q2_d, q1_d;
   logic     sing0_d, sing1_ff, sing1_d, sing2_ff, sing2_d;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= DAMPING_RESET;
      end else if (csr_wr_en) begin
         damping_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   dls_form u_form (.clock, .en, .req_data, .damping(damping_ff), .sum_o(a_w));

   // first pivot: l10, l20, z0
   dls_divq u_div_l10 (.clock, .en, .num(a_w[1]), .den(a_w[0]), .quo(l10));
   dls_divq u_div_l20 (.clock, .en, .num(a_w[3]), .den(a_w[0]), .quo(l20));
   dls_divq u_div_z0  (.clock, .en, .num(a_w[6]), .den(a_w[0]), .quo(z0));

   dls_dly #(.WIDTH(64), .DEPTH(T1-T0)) u_dl_a10 (.clock, .en, .din(a_w[1]), .dout(a10_d));
   dls_dly #(.WIDTH(64), .DEPTH(T1-T0)) u_dl_a20 (.clock, .en, .din(a_w[3]), .dout(a20_d));
   dls_dly #(.WIDTH(64), .DEPTH(T1-T0)) u_dl_b0  (.clock, .en, .din(a_w[6]), .dout(b0_d));
   dls_dly #(.WIDTH(64), .DEPTH(T2-T0)) u_dl_a11 (.clock, .en, .din(a_w[2]), .dout(a11_d));
   dls_dly #(.WIDTH(64), .DEPTH(T2-T0)) u_dl_a21 (.clock, .en, .din(a_w[4]), .dout(a21_d));
   dls_dly #(.WIDTH(64), .DEPTH(T2-T0)) u_dl_a22 (.clock, .en, .din(a_w[5]), .dout(a22_d));
   dls_dly #(.WIDTH(64), .DEPTH(T2-T0)) u_dl_b1  (.clock, .en, .din(a_w[7]), .dout(b1_d));
   dls_dly #(.WIDTH(64), .DEPTH(T2-T0)) u_dl_b2  (.clock, .en, .din(a_w[8]), .dout(b2_d));
   dls_dly #(.WIDTH(1), .DEPTH(T2-T0)) u_dl_s0
      (.clock, .en, .din(not_pos(a_w[0])), .dout(sing0_d));

   dls_mulq u_mul_a (.clock, .en, .a(l10), .b(a10_d), .prod(m_a));
   dls_mulq u_mul_b (.clock, .en, .a(l20), .b(a10_d), .prod(m_b));
   dls_mulq u_mul_c (.clock, .en, .a(l20), .b(a20_d), .prod(m_c));
   dls_mulq u_mul_d (.clock, .en, .a(l10), .b(b0_d),  .prod(m_d));
   dls_mulq u_mul_e (.clock, .en, .a(l20), .b(b0_d),  .prod(m_e));

   assign d1_in = sat_sub(a11_d, m_a);

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff    <= d1_in;
         t_ff     <= sat_sub(a21_d, m_b);
         e_ff     <= sat_sub(a22_d, m_c);
         y1_ff    <= sat_sub(b1_d, m_d);
         w_ff     <= sat_sub(b2_d, m_e);
         sing1_ff <= sing0_d | not_pos(d1_in);
      end
   end

   // second pivot: l21, z1
   dls_divq u_div_l21 (.clock, .en, .num(t_ff),  .den(d1_ff), .quo(l21));
   dls_divq u_div_z1  (.clock, .en, .num(y1_ff), .den(d1_ff), .quo(z1));

   dls_dly #(.WIDTH(64), .DEPTH(T4-T3)) u_dl_t  (.clock, .en, .din(t_ff),  .dout(t_d));
   dls_dly #(.WIDTH(64), .DEPTH(T4-T3)) u_dl_y1 (.clock, .en, .din(y1_ff), .dout(y1_d));
   dls_dly #(.WIDTH(64), .DEPTH(T5-T3)) u_dl_e  (.clock, .en, .din(e_ff),  .dout(e_d));
   dls_dly #(.WIDTH(64), .DEPTH(T5-T3)) u_dl_w  (.clock, .en, .din(w_ff),  .dout(w_d));
   dls_dly #(.WIDTH(1), .DEPTH(T5-T3)) u_dl_s1 (.clock, .en, .din(sing1_ff), .dout(sing1_d));

   dls_mulq u_mul_f (.clock, .en, .a(l21), .b(t_d),  .prod(m_f));
   dls_mulq u_mul_g (.clock, .en, .a(l21), .b(y1_d), .prod(m_g));

   assign d2_in = sat_sub(e_d, m_f);

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff    <= d2_in;
         y2_ff    <= sat_sub(w_d, m_g);
         sing2_ff <= sing1_d | not_pos(d2_in);
      end
   end

   // third pivot: z2 = q2
   dls_divq u_div_z2 (.clock, .en, .num(y2_ff), .den(d2_ff), .quo(z2));

   dls_dly #(.WIDTH(64), .DEPTH(T7-T4)) u_dl_l21 (.clock, .en, .din(l21), .dout(l21_d));
   dls_dly #(.WIDTH(64), .DEPTH(T7-T1)) u_dl_l20 (.clock, .en, .din(l20), .dout(l20_d));
   dls_dly #(.WIDTH(64), .DEPTH(T9-T1)) u_dl_l10 (.clock, .en, .din(l10), .dout(l10_d));
   dls_dly #(.WIDTH(64), .DEPTH(T8-T4)) u_dl_z1  (.clock, .en, .din(z1),  .dout(z1_d));
   dls_dly #(.WIDTH(64), .DEPTH(T10-T1)) u_dl_z0 (.clock, .en, .din(z0),  .dout(z0_d));
   dls_dly #(.WIDTH(1), .DEPTH(T12-T6)) u_dl_s2 (.clock, .en, .din(sing2_ff), .dout(sing2_d));

   dls_mulq u_mul_h (.clock, .en, .a(l21_d), .b(z2), .prod(m_h));
   dls_mulq u_mul_i (.clock, .en, .a(l20_d), .b(z2), .prod(m_i));

   dls_dly #(.WIDTH(64), .DEPTH(T11-T8)) u_dl_mi (.clock, .en, .din(m_i), .dout(m_i_d));
   dls_dly #(.WIDTH(64), .DEPTH(T12-T7)) u_dl_q2 (.clock, .en, .din(z2),  .dout(q2_d));

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff <= sat_sub(z1_d, m_h);
      end
   end

   dls_mulq u_mul_j (.clock, .en, .a(l10_d), .b(q1_ff), .prod(m_j));

   dls_dly #(.WIDTH(64), .DEPTH(T12-T9)) u_dl_q1 (.clock, .en, .din(q1_ff), .dout(q1_d));

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff  <= sat_sub(z0_d, m_j);
         q0_ff <= sat_sub(u_ff, m_i_d);
         rsp_ff.qd0      <= sing2_d ? 32'sd0 : to_q16(q0_ff);
         rsp_ff.qd1      <= sing2_d ? 32'sd0 : to_q16(q1_d);
         rsp_ff.qd2      <= sing2_d ? 32'sd0 : to_q16(q2_d);
         rsp_ff.singular <= sing2_d;
      end
   end

endmodule

// ===== sv/dls_chk.sv =====
// ----------------------------------------------------------------------------
// dls_chk
// Port-level checks for the damped least-squares solve, bound to the top.
// ----------------------------------------------------------------------------
module dls_chk import dls_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input dls_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held response beat changed");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.qd0 == 32'sd0 && rsp_data.qd1 == 32'sd0 && rsp_data.qd2 == 32'sd0)
      else $error("singular beat carries nonzero velocity");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled while output free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind damped_least_squares_3x3_solve dls_chk u_dls_chk (.*);

// ===== test/tb_damped_least_squares_3x3_solve.sv =====
// ----------------------------------------------------------------------------
// tb_damped_least_squares_3x3_solve
// Self-checking bench for the damped least-squares 3x3 solve. A bit-accurate
// Q32.32 predictor computes each expected result from the accepted request
// beat and the current damping. Results are checked in order, field by field.
// Phases sweep damping values and idle/stall patterns, including a long
// response hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_damped_least_squares_3x3_solve;
   import dls_pkg::*;

   typedef logic signed [63:0] q32_type;
   localparam q32_type QTOP = 64'sh7FFF_FFFF_FFFF_FFFF;

   function automatic q32_type qadd(q32_type a, q32_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sd0 + QTOP) return QTOP;
      if (s < -(65'sd0 + QTOP)) return -QTOP;
      return s[63:0];
   endfunction

   function automatic q32_type qsub(q32_type a, q32_type b);
      return qadd(a, -b);
   endfunction

   function automatic logic [63:0] qabs(q32_type a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   function automatic q32_type qmul(q32_type a, q32_type b);
      logic [127:0] p;
      logic neg;
      neg = (a < 0) != (b < 0);
      p = 128'(qabs(a)) * 128'(qabs(b));
      if (p[127:64] >= 64'h8000_0000) return neg ? -QTOP : QTOP;
      return neg ? -q32_type'(p[95:32]) : q32_type'(p[95:32]);
   endfunction

   function automatic q32_type qdiv(q32_type n, q32_type d);
      logic [95:0] num;
      logic [95:0] quo;
      logic neg;
      neg = n < 0;
      num = {qabs(n), 32'd0};
      quo = num / 96'(d);
      if (quo[95:32] >= 64'h8000_0000) return neg ? -QTOP : QTOP;
      return neg ? -q32_type'(quo[63:0]) : q32_type'(quo[63:0]);
   endfunction

   function automatic logic signed [31:0] q16_sat(q32_type x);
      logic [63:0] m;
      logic [31:0] s;
      m = qabs(x) >> 16;
      s = m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
      return x < 0 ? -s : s;
   endfunction

   function automatic dls_rsp_type solve_joint_rates(dls_req_type r, logic [30:0] damp);
      q32_type jm[3][3], v[3], a[3][3], b[3];
      q32_type d0, d1, d2, l10, l20, l21, t, y0, y1, y2, q0, q1, q2;
      dls_rsp_type o;
      jm[0][0] = r.j00; jm[0][1] = r.j01; jm[0][2] = r.j02;
      jm[1][0] = r.j10; jm[1][1] = r.j11; jm[1][2] = r.j12;
      jm[2][0] = r.j20; jm[2][1] = r.j21; jm[2][2] = r.j22;
      v[0] = r.vel_x; v[1] = r.vel_y; v[2] = r.vel_z;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            a[i][c] = 0;
            for (int k = 0; k < 3; k++) a[i][c] = qadd(a[i][c], jm[k][i] * jm[k][c]);
         end
         a[i][i] = qadd(a[i][i], q32_type'({33'd0, damp}) <<< 16);
         b[i] = 0;
         for (int k = 0; k < 3; k++) b[i] = qadd(b[i], jm[k][i] * v[k]);
      end
      o = '0;
      o.singular = 1'b1;
      d0 = a[0][0];
      if (d0 <= 0) return o;
      l10 = qdiv(a[1][0], d0);
      l20 = qdiv(a[2][0], d0);
      d1 = qsub(a[1][1], qmul(l10, a[1][0]));
      if (d1 <= 0) return o;
      t = qsub(a[2][1], qmul(l20, a[1][0]));
      l21 = qdiv(t, d1);
      d2 = qsub(qsub(a[2][2], qmul(l20, a[2][0])), qmul(l21, t));
      if (d2 <= 0) return o;
      y0 = b[0];
      y1 = qsub(b[1], qmul(l10, y0));
      y2 = qsub(qsub(b[2], qmul(l20, y0)), qmul(l21, y1));
      q2 = qdiv(y2, d2);
      q1 = qsub(qdiv(y1, d1), qmul(l21, q2));
      q0 = qsub(qsub(qdiv(y0, d0), qmul(l10, q1)), qmul(l20, q2));
      o.qd0 = q16_sat(q0);
      o.qd1 = q16_sat(q1);
      o.qd2 = q16_sat(q2);
      o.singular = 1'b0;
      return o;
   endfunction

   class joint_rate_board;
      dls_rsp_type pending[$];
      logic [30:0] damping_now = DAMPING_RESET;
      int errors = 0;

      function void note_request(dls_req_type r);
         pending.push_back(solve_joint_rates(r, damping_now));
      endfunction

      function void check_result(dls_rsp_type got);
         dls_rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected result beat qd0=%0d", got.qd0);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.qd0 !== want.qd0) begin
            $error("qd0 expected %0d actual %0d", want.qd0, got.qd0); errors++;
         end
         if (got.qd1 !== want.qd1) begin
            $error("qd1 expected %0d actual %0d", want.qd1, got.qd1); errors++;
         end
         if (got.qd2 !== want.qd2) begin
            $error("qd2 expected %0d actual %0d", want.qd2, got.qd2); errors++;
         end
         if (got.singular !== want.singular) begin
            $error("singular expected %0b actual %0b", want.singular, got.singular);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   dls_req_type req_data = '0;
   dls_rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [DAMP_W-1:0] csr_wr_data = '0;
   int send_idle_pct = 0, stall_pct = 0, hold_off = 0;
   joint_rate_board board = new();

   damped_least_squares_3x3_solve uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'($signed($urandom_range(8)) - 4) <<< 16;
         3: return $signed($urandom_range(131071)) - 65536;
         4: return 32'($urandom_range(1)) << $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   // valid stays up after a beat so the next one can follow with no gap
   task automatic send_beat(dls_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_random(int n);
      dls_req_type r;
      for (int i = 0; i < n; i++) begin
         r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         if ($urandom_range(3) != 0) begin
            r.j00 = rand_q16(); r.j01 = rand_q16(); r.j02 = rand_q16();
            r.j10 = rand_q16(); r.j11 = rand_q16(); r.j12 = rand_q16();
            r.j20 = rand_q16(); r.j21 = rand_q16(); r.j22 = rand_q16();
            r.vel_x = rand_q16(); r.vel_y = rand_q16(); r.vel_z = rand_q16();
            if ($urandom_range(4) == 0) r.j02 = r.j01;
            if ($urandom_range(4) == 0) begin
               r.j00 = 0; r.j10 = 0; r.j20 = 0;
            end
         end
         send_beat(r);
      end
   endtask

   task automatic drain_and_write(logic [30:0] value);
      wait_empty();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      board.damping_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      dls_req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send_beat('0);
      r = '0; r.j00 = 32'sh10000; r.j11 = 32'sh10000; r.j22 = 32'sh10000;
      r.vel_x = 32'sh10000; r.vel_y = -32'sh20000; r.vel_z = 32'sh7FFF_FFFF;
      send_beat(r);
      r = {12{32'sh8000_0000}};
      send_beat(r);
      r = {12{32'sh7FFF_FFFF}};
      send_beat(r);
      r = '0; r.j00 = 32'sh10000; r.j01 = 32'sh10000; r.vel_x = 32'sh10000;
      send_beat(r);
      r = '0; r.j00 = 1; r.j11 = 1; r.j22 = 1; r.vel_x = 32'sh7FFF_FFFF;
      r.vel_y = 32'sh8000_0000; r.vel_z = 32'sh7FFF_FFFF;
      send_beat(r);
      r = {12{32'hFFFF_FFFF}};
      send_beat(r);
      r = {32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
           32'sh70000, 32'sh80000, 32'sh90000, 32'sh10000, 32'sh10000, 32'sh10000};
      send_beat(r);
      drain_and_write('0);
      send_beat(r);
      send_beat('0);
      r = '0; r.j00 = 32'sh10000; r.j11 = 32'sh10000; r.j22 = 32'sh10000;
      r.vel_x = 32'sh5555; send_beat(r);
      send_random(40);
      // random phases
      drain_and_write(31'h7FFF_FFFF);
      send_random(40);
      drain_and_write(31'h0001_0000);
      send_idle_pct = 77;
      send_random(120);
      drain_and_write(31'h5555_5555);
      send_idle_pct = 0; stall_pct = 77;
      send_random(120);
      drain_and_write(DAMPING_RESET);
      send_idle_pct = 35; stall_pct = 35;
      send_random(120);
      drain_and_write(31'h2AAA_AAAA);
      send_idle_pct = 0; stall_pct = 0;
      hold_off = 600;
      send_random(250);
      drain_and_write(31'd1);
      send_random(40);
      wait_empty();
      if (board.errors == 0) begin
         $display("tb_damped_least_squares_3x3_solve: PASS");
      end else begin
         $display("tb_damped_least_squares_3x3_solve: FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_damped_least_squares_3x3_solve: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dls_pkg.sv
sv/dls_dly.sv
sv/dls_mulq.sv
sv/dls_divq.sv
sv/dls_form.sv
sv/damped_least_squares_3x3_solve.sv
sv/dls_chk.sv
test/tb_damped_least_squares_3x3_solve.sv
